// File: rtl/lpbp_pkg.sv
// Package: shared types, codes and constants of the LRU page buffer pool.
package lpbp_pkg;
  localparam int DEF_SLOTS = 16;
  localparam int DEF_MAX_PINS = 255;
  localparam int FILE_W = 8;
  localparam int PAGE_W = 31;
  localparam int MODE_W = 3;
  localparam int STATUS_W = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_GET   = 3'd0,
    MODE_UNPIN = 3'd1,
    MODE_DIRTY = 3'd2,
    MODE_FORCE = 3'd3,
    MODE_FLUSH = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_VICTIM = 3'd1,
    ST_ABSENT    = 3'd2,
    ST_UNPINNED  = 3'd3,
    ST_PIN_LIMIT = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_DECIDE,
    S_WALK_VIC,
    S_WALK_FL,
    S_FL_STEP,
    S_OUT
  } fsm_t;
endpackage

// File: rtl/lpbp_cell.sv
// One slot cell: holds tag, flags and pin count, and compares its tag.
module lpbp_cell import lpbp_pkg::*; #(
  parameter int PIN_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_tag,
  input  logic [FILE_W-1:0] new_file,
  input  logic [PAGE_W-1:0] new_page,
  input  logic              set_use,
  input  logic              clr_use,
  input  logic              set_dirty,
  input  logic              clr_dirty,
  input  logic              pin_load,
  input  logic [PIN_W-1:0]  pin_val,
  input  logic [FILE_W-1:0] key_file,
  input  logic [PAGE_W-1:0] key_page,
  output logic              match,
  output logic              in_use,
  output logic              dirty,
  output logic [PIN_W-1:0]  pins,
  output logic [FILE_W-1:0] file_q,
  output logic [PAGE_W-1:0] page_q
);
  logic              use_r, dirty_r;
  logic [PIN_W-1:0]  pins_r;
  logic [FILE_W-1:0] file_r;
  logic [PAGE_W-1:0] page_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_r   <= 1'b0;
      dirty_r <= 1'b0;
      pins_r  <= '0;
      file_r  <= '0;
      page_r  <= '0;
    end else begin
      if (wr_tag) begin
        file_r <= new_file;
        page_r <= new_page;
      end
      if (set_use) use_r <= 1'b1;
      else if (clr_use) use_r <= 1'b0;
      if (set_dirty) dirty_r <= 1'b1;
      else if (clr_dirty) dirty_r <= 1'b0;
      if (pin_load) pins_r <= pin_val;
    end
  end

  assign match  = use_r && file_r == key_file && page_r == key_page;
  assign in_use = use_r;
  assign dirty  = dirty_r;
  assign pins   = pins_r;
  assign file_q = file_r;
  assign page_q = page_r;
endmodule

// File: rtl/lru_page_buffer_pool.sv
// LRU page buffer pool: one item at a time. A hit, unpin, dirty, force or a miss
// that takes a free slot passes through S_LOOKUP and S_DECIDE. A miss that has to
// walk for a victim visits recency entries from the tail, at most SLOTS of them, in
// S_WALK_VIC. A flush visits recency entries from the head, at most SLOTS of them,
// in S_WALK_FL; its write-back beats go out during the walk. A result beat held by
// out_tready stalls the item. The walk of the recency list, one link per cycle
// while no result beat is held back by out_tready, sets the length of a miss or
// flush. Each slot is a cell with its own tag compare; links are registers.
module lru_page_buffer_pool import lpbp_pkg::*; #(
  parameter int SLOTS    = DEF_SLOTS,
  parameter int MAX_PINS = DEF_MAX_PINS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,  // mode[2:0], file_id[10:3], page_number[41:11]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata, // status, slot_index, hit, load_request,
                                 // writeback_valid, writeback_file, writeback_page
  output logic        out_tlast
);
  localparam int SW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  localparam int PIN_W = $clog2(MAX_PINS + 1);
  localparam logic [LW-1:0] NIL = LW'(SLOTS);
  localparam logic [PIN_W-1:0] PMAX = PIN_W'(MAX_PINS);

  fsm_t state_r, state_nxt;
  logic [MODE_W-1:0] mode_r;
  logic [FILE_W-1:0] file_r;
  logic [PAGE_W-1:0] page_r;
  logic [LW-1:0] prev_r [SLOTS];
  logic [LW-1:0] next_r [SLOTS];
  logic [LW-1:0] free_r, head_r, tail_r;
  logic [LW-1:0] cur_r;
  logic [LW-1:0] steps_r;
  logic          found_r, wrote_r;
  logic [SW-1:0] fslot_r;

  // output register
  logic        ov_r, olast_r;
  logic [STATUS_W-1:0] ost_r;
  logic [3:0]  oslot_r;
  logic        ohit_r, oload_r, owbv_r;
  logic [FILE_W-1:0] owbf_r;
  logic [PAGE_W-1:0] owbp_r;

  logic              c_match [SLOTS];
  logic              c_use [SLOTS];
  logic              c_dirty [SLOTS];
  logic [PIN_W-1:0]  c_pins [SLOTS];
  logic [FILE_W-1:0] c_file [SLOTS];
  logic [PAGE_W-1:0] c_page [SLOTS];
  logic              c_wr [SLOTS], c_suse [SLOTS], c_cuse [SLOTS];
  logic              c_sd [SLOTS], c_cd [SLOTS], c_pl [SLOTS];
  logic [PIN_W-1:0]  c_pv [SLOTS];

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    lpbp_cell #(.PIN_W(PIN_W)) u_cell (
      .clk, .rst_n,
      .wr_tag(c_wr[g]), .new_file(file_r), .new_page(page_r),
      .set_use(c_suse[g]), .clr_use(c_cuse[g]),
      .set_dirty(c_sd[g]), .clr_dirty(c_cd[g]),
      .pin_load(c_pl[g]), .pin_val(c_pv[g]),
      .key_file(file_r), .key_page(page_r),
      .match(c_match[g]), .in_use(c_use[g]), .dirty(c_dirty[g]),
      .pins(c_pins[g]), .file_q(c_file[g]), .page_q(c_page[g])
    );
  end

  // match encoder (tags are unique among used slots)
  logic          hit_c;
  logic [SW-1:0] hslot_c;
  always_comb begin
    hit_c = 1'b0;
    hslot_c = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (c_match[i]) begin
        hit_c = 1'b1;
        hslot_c = SW'(i);
      end
    end
  end

  logic out_free;
  assign out_free = !ov_r || out_tready;
  assign in_tready = state_r == S_IDLE;

  logic [SW-1:0] cur_s;
  assign cur_s = cur_r[SW-1:0];

  // list operations, applied in one clocked block via op codes
  logic          do_unlink, do_push, do_free;
  logic [SW-1:0] op_s;
  logic          emit, e_last;
  logic [STATUS_W-1:0] e_st;
  logic [3:0]    e_slot;
  logic          e_hit, e_load, e_wbv;
  logic [FILE_W-1:0] e_wbf;
  logic [PAGE_W-1:0] e_wbp;
  logic          take_free, cur_adv_prev, cur_adv_next, cur_load_head, cur_load_tail;

  always_comb begin
    state_nxt = state_r;
    do_unlink = 1'b0; do_push = 1'b0; do_free = 1'b0; op_s = '0;
    emit = 1'b0; e_last = 1'b1; e_st = ST_OK; e_slot = '0; e_hit = 1'b0;
    e_load = 1'b0; e_wbv = 1'b0; e_wbf = '0; e_wbp = '0;
    take_free = 1'b0; cur_adv_prev = 1'b0; cur_adv_next = 1'b0;
    cur_load_head = 1'b0; cur_load_tail = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      c_wr[i] = 1'b0; c_suse[i] = 1'b0; c_cuse[i] = 1'b0;
      c_sd[i] = 1'b0; c_cd[i] = 1'b0; c_pl[i] = 1'b0; c_pv[i] = '0;
    end
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_LOOKUP;
      S_LOOKUP: begin
        state_nxt = S_DECIDE;
        if (mode_r == MODE_GET && !hit_c) begin
          if (free_r == NIL) begin
            cur_load_tail = 1'b1;
            state_nxt = S_WALK_VIC;
          end
        end else if (mode_r == MODE_FLUSH) begin
          cur_load_head = 1'b1;
          state_nxt = S_WALK_FL;
        end
      end
      S_DECIDE: if (out_free) begin
        emit = 1'b1;
        state_nxt = S_IDLE;
        unique case (mode_r)
          MODE_GET: begin
            if (hit_c) begin
              e_hit = 1'b1; e_slot = 4'(hslot_c);
              if (c_pins[hslot_c] >= PMAX) e_st = ST_PIN_LIMIT;
              else begin
                c_pl[hslot_c] = 1'b1; c_pv[hslot_c] = c_pins[hslot_c] + 1'b1;
                do_unlink = 1'b1; do_push = 1'b1; op_s = hslot_c;
              end
            end else begin
              // free slot taken (victim path uses S_WALK_VIC instead)
              op_s = free_r[SW-1:0];
              take_free = 1'b1; do_push = 1'b1;
              c_wr[op_s] = 1'b1; c_suse[op_s] = 1'b1; c_cd[op_s] = 1'b1;
              c_pl[op_s] = 1'b1; c_pv[op_s] = PIN_W'(1);
              e_slot = 4'(op_s); e_load = 1'b1;
            end
          end
          MODE_UNPIN, MODE_DIRTY: begin
            if (!hit_c) e_st = ST_ABSENT;
            else if (c_pins[hslot_c] == '0) e_st = ST_UNPINNED;
            else begin
              e_slot = 4'(hslot_c); op_s = hslot_c;
              if (mode_r == MODE_UNPIN) begin
                c_pl[hslot_c] = 1'b1; c_pv[hslot_c] = c_pins[hslot_c] - 1'b1;
                if (c_pins[hslot_c] == PIN_W'(1)) begin
                  do_unlink = 1'b1; do_push = 1'b1;
                end
              end else begin
                c_sd[hslot_c] = 1'b1; do_unlink = 1'b1; do_push = 1'b1;
              end
            end
          end
          MODE_FORCE: begin
            if (hit_c) begin
              e_slot = 4'(hslot_c);
              if (c_dirty[hslot_c]) begin
                c_cd[hslot_c] = 1'b1;
                e_wbv = 1'b1; e_wbf = file_r; e_wbp = page_r;
              end
            end
          end
          default: ;
        endcase
      end
      S_WALK_VIC: begin
        if (cur_r == NIL || steps_r >= LW'(SLOTS)) begin
          if (out_free) begin
            emit = 1'b1; e_st = ST_NO_VICTIM; state_nxt = S_IDLE;
          end
        end else if (c_pins[cur_s] != '0) begin
          cur_adv_prev = 1'b1;
        end else if (out_free) begin
          emit = 1'b1; state_nxt = S_IDLE;
          op_s = cur_s; do_unlink = 1'b1; do_push = 1'b1;
          e_wbv = c_dirty[cur_s];
          e_wbf = c_dirty[cur_s] ? c_file[cur_s] : '0;
          e_wbp = c_dirty[cur_s] ? c_page[cur_s] : '0;
          c_wr[cur_s] = 1'b1; c_suse[cur_s] = 1'b1; c_cd[cur_s] = 1'b1;
          c_pl[cur_s] = 1'b1; c_pv[cur_s] = PIN_W'(1);
          e_slot = 4'(cur_s); e_load = 1'b1;
        end
      end
      S_WALK_FL: begin
        if (cur_r == NIL || steps_r >= LW'(SLOTS)) begin
          if (!wrote_r) begin
            if (out_free) begin
              emit = 1'b1; state_nxt = S_IDLE;
            end
          end else if (out_free) begin
            emit = 1'b1; state_nxt = S_IDLE;
            e_slot = 4'(fslot_r); e_wbv = 1'b1;
            e_wbf = file_r; e_wbp = c_page[fslot_r];
          end
        end else if (c_file[cur_s] == file_r && c_pins[cur_s] == '0) begin
          // a dirty page is held back one beat so the last one carries tlast
          if (!c_dirty[cur_s] || !found_r || out_free) begin
            if (c_dirty[cur_s] && found_r) begin
              emit = 1'b1; e_last = 1'b0;
              e_slot = 4'(fslot_r); e_wbv = 1'b1;
              e_wbf = file_r; e_wbp = c_page[fslot_r];
            end
            c_cd[cur_s] = 1'b1; c_cuse[cur_s] = 1'b1;
            op_s = cur_s; do_unlink = 1'b1; do_free = 1'b1;
            cur_adv_next = 1'b1;
          end
        end else begin
          cur_adv_next = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // pending dirty flush page: page kept in cell, tag left in place on free
  logic fl_dirty_hit;
  assign fl_dirty_hit = state_r == S_WALK_FL && cur_r != NIL && steps_r < LW'(SLOTS)
    && c_file[cur_s] == file_r && c_pins[cur_s] == '0 && c_dirty[cur_s] && cur_adv_next;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      free_r  <= '0;
      head_r  <= NIL;
      tail_r  <= NIL;
      for (int i = 0; i < SLOTS; i++) begin
        prev_r[i] <= NIL;
        next_r[i] <= LW'(i + 1);
      end
      cur_r <= NIL; steps_r <= '0; found_r <= 1'b0; wrote_r <= 1'b0; fslot_r <= '0;
      ov_r <= 1'b0; olast_r <= 1'b0;
    end else begin
      logic [LW-1:0] h, t, pp, nn;
      h = head_r; t = tail_r;
      state_r <= state_nxt;
      if (state_r == S_IDLE && in_tvalid) begin
        mode_r <= in_tdata[2:0];
        file_r <= in_tdata[10:3];
        page_r <= in_tdata[41:11];
        steps_r <= '0; found_r <= 1'b0; wrote_r <= 1'b0;
      end
      if (cur_load_head) cur_r <= head_r;
      if (cur_load_tail) cur_r <= tail_r;
      if (cur_adv_prev) begin
        cur_r <= prev_r[cur_s]; steps_r <= steps_r + 1'b1;
      end
      if (cur_adv_next) begin
        cur_r <= next_r[cur_s]; steps_r <= steps_r + 1'b1;
      end
      if (fl_dirty_hit) begin
        found_r <= 1'b1; wrote_r <= 1'b1; fslot_r <= cur_s;
      end
      if (take_free) free_r <= next_r[op_s];
      if (do_unlink) begin
        pp = prev_r[op_s]; nn = next_r[op_s];
        if (h == LW'(op_s)) h = nn;
        if (t == LW'(op_s)) t = pp;
        // a head moved to the front again gets its successor relinked by the push
        if (nn != NIL && !(do_push && head_r == LW'(op_s))) prev_r[nn[SW-1:0]] <= pp;
        if (pp != NIL) next_r[pp[SW-1:0]] <= nn;
      end
      if (do_push) begin
        next_r[op_s] <= h;
        prev_r[op_s] <= NIL;
        if (h != NIL) prev_r[h[SW-1:0]] <= LW'(op_s);
        h = LW'(op_s);
        if (t == NIL) t = LW'(op_s);
      end
      if (do_free) begin
        next_r[op_s] <= free_r;
        prev_r[op_s] <= NIL;
        free_r <= LW'(op_s);
      end
      head_r <= h; tail_r <= t;
      if (emit) begin
        ov_r <= 1'b1; olast_r <= e_last; ost_r <= e_st; oslot_r <= e_slot;
        ohit_r <= e_hit; oload_r <= e_load; owbv_r <= e_wbv;
        owbf_r <= e_wbf; owbp_r <= e_wbp;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {6'd0, owbp_r, owbf_r, owbv_r, oload_r, ohit_r, oslot_r, ost_r};

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free) else $error("beat overwritten");
  a_head_prev: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && head_r != NIL) |-> prev_r[head_r[SW-1:0]] == NIL)
    else $error("head has a predecessor");
  a_free_unused: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && free_r != NIL) |-> !c_use[free_r[SW-1:0]])
    else $error("free list head is in use");
endmodule
